// ===== rtl/core/strongest_light_selector_defines.svh =====
// Assertion macros shared by the selector RTL
`ifndef STRONGEST_LIGHT_SELECTOR_DEFINES_SVH
`define STRONGEST_LIGHT_SELECTOR_DEFINES_SVH

// Implication checked at every rising edge outside reset
`define SLS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked at every rising edge outside reset
`define SLS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/sls_pkg.sv =====
package sls_pkg;
    localparam int MaxLights   = 128;
    localparam int ListSlots   = 3;
    localparam int CoordWidth  = 24;
    localparam int RadWidth    = 23;
    localparam int ScoreWidth  = 18;
    localparam int IdxWidth    = 7;
    localparam int CountWidth  = $clog2(MaxLights + 1);
    localparam int SlotWidth   = 2;
    localparam int DiffWidth   = CoordWidth + 1;
    // squared distance is compared only when each |diff| < outer < 2^23
    localparam int D2Width     = 2 * RadWidth + 2;
    localparam int SqrtSteps   = D2Width / 2;
    localparam int DivSteps    = 16;

    localparam logic [1:0] ModeStart  = 2'd0;
    localparam logic [1:0] ModeLight  = 2'd1;
    localparam logic [1:0] ModeFinish = 2'd2;

    localparam logic [3:0] TypeEnd     = 4'd0;
    localparam logic [3:0] TypeAmbient = 4'd1;
    localparam logic [3:0] TypeFixed   = 4'd5;
    localparam logic [3:0] TypeIgnored = 4'd7;

    localparam logic [ScoreWidth-1:0] ScoreOne = 18'h10000;
    localparam logic [ScoreWidth-1:0] ScoreTwo = 18'h20000;

    // controller to datapath commands
    typedef struct packed {
        logic load_query;   // latch query, clear lists
        logic load_light;   // latch light operands
        logic diff_step;    // compute abs diffs and outer check
        logic sq_step;      // accumulate one squared term
        logic sqrt_init;
        logic sqrt_step;
        logic div_init;
        logic div_step;
        logic insert;
        logic emit;
        logic [SlotWidth:0] emit_sel;
    } t_cmd;

    typedef struct packed {
        logic far;        // diff or d2 beyond outer
        logic degenerate; // inner >= outer
        logic near;       // d <= inner
    } t_status;
endpackage

// ===== rtl/core/sls_datapath.sv =====
module sls_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sls_pkg::t_cmd                       i_cmd,
    input  logic [1:0]                          i_sq_sel,
    input  logic signed [sls_pkg::CoordWidth-1:0] i_pos_x,
    input  logic signed [sls_pkg::CoordWidth-1:0] i_pos_y,
    input  logic signed [sls_pkg::CoordWidth-1:0] i_pos_z,
    input  logic [3:0]                          i_light_type,
    input  logic [sls_pkg::RadWidth-1:0]        i_inner_radius,
    input  logic [sls_pkg::RadWidth-1:0]        i_outer_radius,
    input  logic [sls_pkg::IdxWidth-1:0]        i_index,
    input  logic                                i_use_fixed,
    output sls_pkg::t_status                    o_status,
    output logic                                o_list_kind,
    output logic [1:0]                          o_slot,
    output logic                                o_valid_res,
    output logic [sls_pkg::IdxWidth-1:0]        o_light_index,
    output logic [sls_pkg::ScoreWidth-1:0]      o_score,
    output logic                                o_last
);
    import sls_pkg::*;

    logic signed [CoordWidth-1:0] r_q [3];
    logic signed [CoordWidth-1:0] r_l [3];
    logic [RadWidth-1:0] r_inner, r_outer;
    logic [3:0] r_type;
    logic [IdxWidth-1:0] r_index;
    logic [DiffWidth-1:0] r_ad [3];
    logic [D2Width-1:0] r_d2;
    logic [D2Width-1:0] r_rem;
    logic [D2Width-1:0] r_root;
    logic [D2Width-1:0] r_bit;
    logic [RadWidth:0] r_num;
    logic [RadWidth:0] r_dvr;
    logic [ScoreWidth-1:0] r_quot;
    logic [IdxWidth-1:0] r_dir_idx [ListSlots];
    logic [ScoreWidth-1:0] r_dir_sc [ListSlots];
    logic [IdxWidth-1:0] r_amb_idx [ListSlots];
    logic [ScoreWidth-1:0] r_amb_sc [ListSlots];

    logic [DiffWidth-1:0] ad_sel;
    logic [2*DiffWidth-1:0] sq;
    logic [D2Width-1:0] outer_sq;
    logic [D2Width-1:0] trial;
    logic [RadWidth:0] num_dbl;
    logic [ScoreWidth-1:0] new_score;
    logic [ScoreWidth-1:0] list_sc [ListSlots];
    logic [IdxWidth-1:0] list_idx [ListSlots];
    logic emit_amb;
    logic [SlotWidth-1:0] emit_slot;
    logic [ScoreWidth-1:0] emit_sc;
    logic [IdxWidth-1:0] emit_idx;

    function automatic logic [DiffWidth-1:0] abs_diff(
        input logic signed [CoordWidth-1:0] a,
        input logic signed [CoordWidth-1:0] b
    );
        logic signed [DiffWidth-1:0] d;
        d = DiffWidth'(a) - DiffWidth'(b);
        return d[DiffWidth-1] ? DiffWidth'(-d) : d;
    endfunction

    assign ad_sel = r_ad[i_sq_sel];
    assign sq = ad_sel * ad_sel;
    assign outer_sq = D2Width'(r_outer) * D2Width'(r_outer);
    assign trial = r_root + r_bit;
    assign num_dbl = {r_num[RadWidth-1:0], 1'b0};
    assign new_score = i_use_fixed ? ScoreTwo : r_quot;

    always_comb begin
        for (int s = 0; s < ListSlots; s++) begin
            list_sc[s]  = (r_type == TypeAmbient) ? r_amb_sc[s] : r_dir_sc[s];
            list_idx[s] = (r_type == TypeAmbient) ? r_amb_idx[s] : r_dir_idx[s];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_query) begin
            r_q[0] <= i_pos_x;
            r_q[1] <= i_pos_y;
            r_q[2] <= i_pos_z;
        end
        if (i_cmd.load_light) begin
            r_l[0]  <= i_pos_x;
            r_l[1]  <= i_pos_y;
            r_l[2]  <= i_pos_z;
            r_inner <= i_inner_radius;
            r_outer <= i_outer_radius;
            r_type  <= i_light_type;
            r_index <= i_index;
            r_d2    <= '0;
        end
        if (i_cmd.diff_step) begin
            for (int k = 0; k < 3; k++) r_ad[k] <= abs_diff(r_q[k], r_l[k]);
        end
        if (i_cmd.sq_step) r_d2 <= r_d2 + D2Width'(sq);
        if (i_cmd.sqrt_init) begin
            r_rem  <= r_d2;
            r_root <= '0;
            r_bit  <= D2Width'(1) << (D2Width - 2);
            // far scores zero; degenerate radii score one
            r_quot <= (o_status.degenerate && !o_status.far) ? ScoreOne : '0;
        end
        if (i_cmd.sqrt_step) begin
            if (r_rem >= trial) begin
                r_rem  <= r_rem - trial;
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (i_cmd.div_init) begin
            // remainder starts at outer - d, below the divisor; shift in 16 zero bits
            r_num  <= (RadWidth+1)'(r_outer) - (RadWidth+1)'(r_root);
            r_dvr  <= (RadWidth+1)'(r_outer) - (RadWidth+1)'(r_inner);
            r_quot <= o_status.near ? ScoreOne : '0;
        end
        if (i_cmd.div_step) begin
            if (num_dbl >= r_dvr) begin
                r_num  <= num_dbl - r_dvr;
                r_quot <= {r_quot[ScoreWidth-2:0], 1'b1};
            end else begin
                r_num  <= num_dbl;
                r_quot <= {r_quot[ScoreWidth-2:0], 1'b0};
            end
        end
    end

    // list registers, cleared on reset and on start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load_query) begin
            for (int s = 0; s < ListSlots; s++) begin
                r_dir_idx[s] <= '0;
                r_dir_sc[s]  <= '0;
                r_amb_idx[s] <= '0;
                r_amb_sc[s]  <= '0;
            end
        end else if (i_cmd.insert && new_score != '0 && r_type != TypeIgnored) begin
            for (int s = 0; s < ListSlots; s++) begin
                logic beat_here, beat_before;
                beat_here   = list_sc[s] < new_score;
                beat_before = 1'b0;
                for (int m = 0; m < s; m++) beat_before |= list_sc[m] < new_score;
                if (r_type == TypeAmbient) begin
                    if (beat_before) begin
                        r_amb_sc[s]  <= list_sc[(s > 0) ? s - 1 : 0];
                        r_amb_idx[s] <= list_idx[(s > 0) ? s - 1 : 0];
                    end else if (beat_here) begin
                        r_amb_sc[s]  <= new_score;
                        r_amb_idx[s] <= r_index;
                    end
                end else begin
                    if (beat_before) begin
                        r_dir_sc[s]  <= list_sc[(s > 0) ? s - 1 : 0];
                        r_dir_idx[s] <= list_idx[(s > 0) ? s - 1 : 0];
                    end else if (beat_here) begin
                        r_dir_sc[s]  <= new_score;
                        r_dir_idx[s] <= r_index;
                    end
                end
            end
        end
    end

    assign o_status.far = (r_ad[0] >= DiffWidth'(r_outer)) || (r_ad[1] >= DiffWidth'(r_outer))
                       || (r_ad[2] >= DiffWidth'(r_outer)) || (r_d2 >= outer_sq);
    assign o_status.degenerate = r_inner >= r_outer;
    assign o_status.near = r_root <= D2Width'(r_inner);

    assign emit_amb  = i_cmd.emit_sel >= (SlotWidth+1)'(ListSlots);
    assign emit_slot = SlotWidth'(emit_amb ? i_cmd.emit_sel - (SlotWidth+1)'(ListSlots)
                                           : i_cmd.emit_sel);
    assign emit_sc   = emit_amb ? r_amb_sc[emit_slot] : r_dir_sc[emit_slot];
    assign emit_idx  = emit_amb ? r_amb_idx[emit_slot] : r_dir_idx[emit_slot];

    always_ff @(posedge i_clk) begin
        o_list_kind   <= emit_amb;
        o_slot        <= emit_slot;
        o_valid_res   <= emit_sc != '0;
        o_light_index <= (emit_sc != '0) ? emit_idx : '0;
        o_score       <= emit_sc;
        o_last        <= i_cmd.emit_sel == (SlotWidth+1)'(2 * ListSlots - 1);
    end
endmodule

// ===== rtl/core/sls_ctrl.sv =====
module sls_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [1:0]                    i_mode,
    input  logic [3:0]                    i_light_type,
    input  sls_pkg::t_status              i_status,
    output logic                          o_busy,
    output sls_pkg::t_cmd                 o_cmd,
    output logic [1:0]                    o_sq_sel,
    output logic [sls_pkg::IdxWidth-1:0]  o_index,
    output logic                          o_use_fixed,
    output logic                          o_strobe
);
    import sls_pkg::*;
    `include "strongest_light_selector_defines.svh"

    typedef enum logic [3:0] {
        S_IDLE, S_DIFF, S_SQ, S_CHECK, S_SQRT, S_NEAR, S_DIV, S_INSERT, S_EMIT
    } t_state;

    t_state r_state;
    logic [CountWidth-1:0] r_count;
    logic r_open;
    logic [4:0] r_step;
    logic [SlotWidth:0] r_emit;
    logic r_strobe;
    logic r_fixed;
    logic take;

    assign take = i_start && !o_busy;
    assign o_busy = r_state != S_IDLE;
    assign o_sq_sel = r_step[1:0];
    assign o_index = r_count[IdxWidth-1:0];
    assign o_use_fixed = r_fixed;
    assign o_strobe = r_strobe;

    always_comb begin
        o_cmd = '0;
        o_cmd.load_query = take && i_mode == ModeStart;
        o_cmd.load_light = take && i_mode == ModeLight;
        o_cmd.diff_step  = r_state == S_DIFF;
        o_cmd.sq_step    = r_state == S_SQ;
        o_cmd.sqrt_init  = r_state == S_CHECK;
        o_cmd.sqrt_step  = r_state == S_SQRT;
        o_cmd.div_init   = r_state == S_NEAR;
        o_cmd.div_step   = r_state == S_DIV;
        o_cmd.insert     = r_state == S_INSERT;
        o_cmd.emit       = r_state == S_EMIT;
        o_cmd.emit_sel   = r_emit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_open   <= 1'b0;
            r_step   <= '0;
            r_emit   <= '0;
            r_strobe <= 1'b0;
            r_fixed  <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (take) begin
                        priority if (i_mode == ModeStart) begin
                            r_count <= '0;
                            r_open  <= 1'b1;
                        end else if (i_mode == ModeLight) begin
                            if (r_open && r_count < CountWidth'(MaxLights)) begin
                                if (i_light_type == TypeEnd) begin
                                    r_open <= 1'b0;
                                end else begin
                                    r_fixed <= i_light_type == TypeFixed;
                                    r_state <= (i_light_type == TypeFixed) ? S_INSERT : S_DIFF;
                                end
                            end
                        end else if (i_mode == ModeFinish) begin
                            r_emit  <= '0;
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_DIFF: begin
                    r_step  <= '0;
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'd2) r_state <= S_CHECK;
                end
                S_CHECK: begin
                    r_step <= '0;
                    // score zero drops the light; one skips the root
                    priority if (i_status.far) begin
                        r_fixed <= 1'b0;
                        r_state <= S_INSERT;
                    end else if (i_status.degenerate) begin
                        r_state <= S_INSERT;
                    end else begin
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'(SqrtSteps - 1)) r_state <= S_NEAR;
                end
                S_NEAR: begin
                    r_step  <= '0;
                    // inside the inner radius scores one: skip the divide
                    r_state <= i_status.near ? S_INSERT : S_DIV;
                end
                S_DIV: begin
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'(DivSteps - 1)) r_state <= S_INSERT;
                end
                S_INSERT: begin
                    r_count <= r_count + CountWidth'(1);
                    r_state <= S_IDLE;
                end
                S_EMIT: begin
                    r_strobe <= 1'b1;
                    r_emit   <= r_emit + (SlotWidth+1)'(1);
                    if (r_emit == (SlotWidth+1)'(2 * ListSlots - 1)) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `SLS_ASSERT_IMP(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= CountWidth'(MaxLights))
    `SLS_ASSERT_NXT(a_emit_busy, i_clk, i_rst_n, r_state == S_EMIT, r_strobe)
    `SLS_ASSERT_IMP(a_no_take_busy, i_clk, i_rst_n, r_state != S_IDLE, !take)
endmodule

// ===== rtl/core/strongest_light_selector.sv =====
// A start, or a light that is dropped, needs only its transfer; a fixed light goes straight to insert.
//   A scored light runs diff, squares, check, root, near, divide and insert; far or degenerate radii
//   go from check to insert, and a light inside the inner radius skips the divide.
// Finish returns six o_strobe results, one a cycle.
// Throughput: one item at a time; busy holds start off while any item runs, the shared root and divide too.
// Synchronous active-low reset closes the scan and clears both lists; the receiver cannot stall.
module strongest_light_selector (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic [1:0]                              i_mode,
    input  logic signed [sls_pkg::CoordWidth-1:0]   i_pos_x,
    input  logic signed [sls_pkg::CoordWidth-1:0]   i_pos_y,
    input  logic signed [sls_pkg::CoordWidth-1:0]   i_pos_z,
    input  logic [3:0]                              i_light_type,
    input  logic [sls_pkg::RadWidth-1:0]            i_inner_radius,
    input  logic [sls_pkg::RadWidth-1:0]            i_outer_radius,
    output logic                                    o_strobe,
    output logic                                    o_list_kind,
    output logic [1:0]                              o_slot,
    output logic                                    o_valid_res,
    output logic [sls_pkg::IdxWidth-1:0]            o_light_index,
    output logic [sls_pkg::ScoreWidth-1:0]          o_score,
    output logic                                    o_last
);
    import sls_pkg::*;

    t_cmd cmd;
    t_status status;
    logic [1:0] sq_sel;
    logic [IdxWidth-1:0] index;
    logic use_fixed;

    sls_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_mode(i_mode),
        .i_light_type(i_light_type), .i_status(status), .o_busy(busy),
        .o_cmd(cmd), .o_sq_sel(sq_sel), .o_index(index),
        .o_use_fixed(use_fixed), .o_strobe(o_strobe)
    );

    sls_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_sq_sel(sq_sel),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_pos_z(i_pos_z),
        .i_light_type(i_light_type), .i_inner_radius(i_inner_radius),
        .i_outer_radius(i_outer_radius), .i_index(index), .i_use_fixed(use_fixed),
        .o_status(status), .o_list_kind(o_list_kind), .o_slot(o_slot),
        .o_valid_res(o_valid_res), .o_light_index(o_light_index),
        .o_score(o_score), .o_last(o_last)
    );
endmodule
